>>> hdl/bnx_pkg.sv
// Shared constants and types for the advertising local-name extractor.
// Used by the parser, the emitter and the top level; depends on nothing.
package bnx_pkg;

    localparam int MAX_AD_BYTES = 31;
    localparam int NAME_DEPTH   = MAX_AD_BYTES - 2;
    localparam int CNT_W        = $clog2(NAME_DEPTH + 1);
    localparam int ADDR_W       = $clog2(NAME_DEPTH);
    localparam int CHAR_W       = 7;
    localparam int LEN_W        = 5;
    localparam int OFS_W        = LEN_W + 1;

    localparam logic [7:0] TYPE_COMPLETE = 8'h09;
    localparam logic [7:0] TYPE_SHORT    = 8'h08;
    localparam logic [7:0] CHAR_LOW      = 8'h20;
    localparam logic [7:0] CHAR_HIGH     = 8'h7E;

    // Handed from the parser to the emitter when the final byte of a report is taken.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             from_complete;
    } t_name_done;

endpackage

>>> hdl/bnx_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Self-contained; used for the name character store.
module bnx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/bnx_parser.sv
// Record walker: follows the length-type-value records of one payload and
// writes printable name characters into the name RAM. Depends on bnx_pkg.
module bnx_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_data_byte,
    input  logic [bnx_pkg::LEN_W-1:0]     i_ad_length,
    input  logic                          i_last_byte,
    output logic                          o_wr_en,
    output logic [bnx_pkg::ADDR_W-1:0]    o_wr_addr,
    output logic [bnx_pkg::CHAR_W-1:0]    o_wr_data,
    output bnx_pkg::t_name_done           o_done
);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_VALUE,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_SHORT,
        KIND_COMPLETE
    } t_kind;

    t_phase                      r_phase,  n_phase;
    t_kind                       r_kind,   n_kind;
    logic [bnx_pkg::OFS_W-1:0]   r_offset, n_offset;
    logic [bnx_pkg::LEN_W-1:0]   r_left,   n_left;
    logic [bnx_pkg::CNT_W-1:0]   r_count,  n_count;
    logic                        r_short_taken, n_short_taken;
    logic                        r_complete,    n_complete;

    logic [8:0]                  c_rec_end;
    logic                        c_printable;

    assign c_rec_end   = 9'({3'b000, r_offset}) + 9'({1'b0, i_data_byte}) + 9'd1;
    assign c_printable = (i_data_byte >= bnx_pkg::CHAR_LOW) &&
                         (i_data_byte <= bnx_pkg::CHAR_HIGH);

    always_comb begin
        t_phase c_ph;
        c_ph          = r_phase;
        n_phase       = r_phase;
        n_kind        = r_kind;
        n_offset      = r_offset;
        n_left        = r_left;
        n_count       = r_count;
        n_short_taken = r_short_taken;
        n_complete    = r_complete;
        o_wr_en       = 1'b0;
        o_wr_addr     = r_count[bnx_pkg::ADDR_W-1:0];
        o_wr_data     = i_data_byte[bnx_pkg::CHAR_W-1:0];
        o_done        = '0;

        if (i_accept && (i_ad_length != '0)) begin
            // Anything at or past the declared length ends parsing.
            if (r_phase != PH_DONE && r_offset >= {1'b0, i_ad_length}) begin
                c_ph = PH_DONE;
            end
            n_phase = c_ph;
            unique case (c_ph)
                PH_LEN: begin
                    if (i_data_byte == 8'd0 || c_rec_end > 9'({4'b0000, i_ad_length})) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_left  = i_data_byte[bnx_pkg::LEN_W-1:0];
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_left = r_left - 1'b1;
                    n_kind = KIND_OTHER;
                    if (i_data_byte == bnx_pkg::TYPE_COMPLETE && n_left != '0) begin
                        n_kind     = KIND_COMPLETE;
                        n_complete = 1'b1;
                        n_count    = '0;
                    end else if (i_data_byte == bnx_pkg::TYPE_SHORT && n_left != '0 &&
                                 !r_short_taken) begin
                        n_kind        = KIND_SHORT;
                        n_short_taken = 1'b1;
                        n_count       = '0;
                    end
                    n_phase = (n_left == '0) ? PH_LEN : PH_VALUE;
                end
                PH_VALUE: begin
                    if (r_kind != KIND_OTHER && c_printable &&
                        r_count < bnx_pkg::CNT_W'(bnx_pkg::NAME_DEPTH)) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    n_left = r_left - 1'b1;
                    if (n_left == '0) begin
                        n_phase = (r_kind == KIND_COMPLETE) ? PH_DONE : PH_LEN;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
            if (r_offset != '1) begin
                n_offset = r_offset + 1'b1;
            end
        end

        if (i_accept && i_last_byte) begin
            o_done.valid         = 1'b1;
            o_done.count         = (i_ad_length == '0) ? '0 : n_count;
            o_done.from_complete = (i_ad_length == '0) ? 1'b0 : n_complete;
            n_phase       = PH_LEN;
            n_kind        = KIND_OTHER;
            n_offset      = '0;
            n_left        = '0;
            n_count       = '0;
            n_short_taken = 1'b0;
            n_complete    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LEN;
            r_kind        <= KIND_OTHER;
            r_offset      <= '0;
            r_left        <= '0;
            r_count       <= '0;
            r_short_taken <= 1'b0;
            r_complete    <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_kind        <= n_kind;
            r_offset      <= n_offset;
            r_left        <= n_left;
            r_count       <= n_count;
            r_short_taken <= n_short_taken;
            r_complete    <= n_complete;
        end
    end

endmodule

>>> hdl/bnx_emitter.sv
// Name emitter: reads the stored characters back from the name RAM and drives
// the result register, or sends one empty terminator. Depends on bnx_pkg.
module bnx_emitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bnx_pkg::t_name_done           i_done,
    output logic                          o_busy,
    output logic                          o_rd_en,
    output logic [bnx_pkg::ADDR_W-1:0]    o_rd_addr,
    input  logic [bnx_pkg::CHAR_W-1:0]    i_rd_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bnx_pkg::CHAR_W-1:0]    o_name_char,
    output logic                          o_char_valid,
    output logic                          o_name_last,
    output logic                          o_from_complete
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_TERM,
        E_READ,
        E_CAP
    } t_state;

    t_state                      r_state;
    logic [bnx_pkg::CNT_W-1:0]   r_idx;
    logic [bnx_pkg::CNT_W-1:0]   r_total;
    logic                        r_complete;
    logic                        r_out_valid;
    logic [bnx_pkg::CHAR_W-1:0]  r_name_char;
    logic                        r_char_valid;
    logic                        r_name_last;
    logic                        r_from_complete;
    logic                        c_out_free;
    logic                        c_final;
    logic                        c_load;

    assign c_out_free = !r_out_valid || i_out_ready;
    assign c_final    = (r_idx + 1'b1) == r_total;
    assign c_load     = ((r_state == E_TERM) || (r_state == E_CAP)) && c_out_free;

    assign o_busy    = (r_state != E_IDLE);
    assign o_rd_en   = (r_state == E_READ);
    assign o_rd_addr = r_idx[bnx_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_total     <= '0;
            r_complete  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !c_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_done.valid) begin
                        r_idx      <= '0;
                        r_total    <= i_done.count;
                        r_complete <= i_done.from_complete;
                        r_state    <= (i_done.count == '0) ? E_TERM : E_READ;
                    end
                end
                E_TERM: begin
                    if (c_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_name_char     <= '0;
                        r_char_valid    <= 1'b0;
                        r_name_last     <= 1'b1;
                        r_from_complete <= r_complete;
                        r_state         <= E_IDLE;
                    end
                end
                E_READ: begin
                    r_state <= E_CAP;
                end
                E_CAP: begin
                    // Read data holds here because no new read is issued until it is taken.
                    if (c_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_name_char     <= i_rd_data;
                        r_char_valid    <= 1'b1;
                        r_name_last     <= c_final;
                        r_from_complete <= r_complete;
                        r_idx           <= r_idx + 1'b1;
                        r_state         <= c_final ? E_IDLE : E_READ;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_name_char     = r_name_char;
    assign o_char_valid    = r_char_valid;
    assign o_name_last     = r_name_last;
    assign o_from_complete = r_from_complete;

endmodule

>>> hdl/ble_adv_name_extractor_unit.sv
// Advertising local-name extractor, top level: parser, name RAM and emitter.
// Depends on bnx_pkg, bnx_parser, bnx_ram and bnx_emitter.
//
// Payload bytes are taken one request per cycle while no name is being sent.
// After the final byte the block stops taking requests and sends the chosen
// name from the 29-entry name RAM, each character first read from the RAM
// (E_READ) and then loaded into the result register (E_CAP), or passes through
// E_TERM to load one empty terminator into the result register. The input
// stays closed until the final character or the terminator is loaded, and an
// output stall keeps it closed longer. The complete local name wins over the
// first shortened name, and only printable characters are kept.
module ble_adv_name_extractor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic [bnx_pkg::LEN_W-1:0]     i_ad_length,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bnx_pkg::CHAR_W-1:0]    o_name_char,
    output logic                          o_char_valid,
    output logic                          o_name_last,
    output logic                          o_from_complete
);

    logic                          c_accept;
    logic                          c_busy;
    logic                          c_wr_en;
    logic [bnx_pkg::ADDR_W-1:0]    c_wr_addr;
    logic [bnx_pkg::CHAR_W-1:0]    c_wr_data;
    logic                          c_rd_en;
    logic [bnx_pkg::ADDR_W-1:0]    c_rd_addr;
    logic [bnx_pkg::CHAR_W-1:0]    c_rd_data;
    bnx_pkg::t_name_done           c_done;

    assign o_in_ready = !c_busy;
    assign c_accept   = i_in_valid && !c_busy;

    bnx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (c_accept),
        .i_data_byte (i_data_byte),
        .i_ad_length (i_ad_length),
        .i_last_byte (i_last_byte),
        .o_wr_en     (c_wr_en),
        .o_wr_addr   (c_wr_addr),
        .o_wr_data   (c_wr_data),
        .o_done      (c_done)
    );

    bnx_ram #(
        .WIDTH (bnx_pkg::CHAR_W),
        .DEPTH (bnx_pkg::NAME_DEPTH)
    ) u_name_ram (
        .i_clk     (i_clk),
        .i_wr_en   (c_wr_en),
        .i_wr_addr (c_wr_addr),
        .i_wr_data (c_wr_data),
        .i_rd_en   (c_rd_en),
        .i_rd_addr (c_rd_addr),
        .o_rd_data (c_rd_data)
    );

    bnx_emitter u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_done          (c_done),
        .o_busy          (c_busy),
        .o_rd_en         (c_rd_en),
        .o_rd_addr       (c_rd_addr),
        .i_rd_data       (c_rd_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_name_char     (o_name_char),
        .o_char_valid    (o_char_valid),
        .o_name_last     (o_name_last),
        .o_from_complete (o_from_complete)
    );

endmodule

>>> hdl/bnx_checker.sv
// Port-level checks for the advertising local-name extractor.
// Bound to ble_adv_name_extractor_unit; depends on bnx_pkg.
module bnx_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          i_last_byte,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [bnx_pkg::CHAR_W-1:0]    o_name_char,
    input  logic                          o_char_valid,
    input  logic                          o_name_last,
    input  logic                          o_from_complete
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_name_char) && $stable(o_char_valid) &&
            $stable(o_name_last) && $stable(o_from_complete))
        else $error("result changed while stalled");

    // An empty terminator is always the final result and carries no character.
    a_term_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_valid |-> o_name_last && o_name_char == '0)
        else $error("malformed empty terminator");

    // Only printable characters leave the block.
    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_char_valid |->
            o_name_char >= 7'h20 && o_name_char <= 7'h7E)
        else $error("unprintable name character");

    // Taking the final byte closes the input while the name goes out.
    a_close_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_byte |=> !o_in_ready)
        else $error("input still open after final byte");

endmodule

bind ble_adv_name_extractor_unit bnx_checker u_bnx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_last_byte     (i_last_byte),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_name_char     (o_name_char),
    .o_char_valid    (o_char_valid),
    .o_name_last     (o_name_last),
    .o_from_complete (o_from_complete)
);

>>> test/tb_top.sv
// Self-checking testbench for ble_adv_name_extractor_unit: random and directed
// advertising payloads in, name characters checked against a cycle-free predictor.
// Depends on bnx_pkg and the extractor RTL only.
module tb_top;

    typedef enum logic [1:0] {PH_LENGTH, PH_TYPE, PH_VALUE, PH_DONE} t_parse_phase;
    typedef enum logic [1:0] {KIND_OTHER, KIND_SHORT, KIND_COMPLETE} t_record_kind;
    typedef enum logic [1:0] {
        PACE_STEADY, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH_GAPS
    } t_pace;

    typedef struct {
        logic [7:0]                data;
        logic [bnx_pkg::LEN_W-1:0] len;
        logic                      last;
        t_pace                     pace;
        bit                        drain;
    } t_ad_request;

    typedef struct {
        logic [bnx_pkg::CHAR_W-1:0] ch;
        logic                       char_valid;
        logic                       name_last;
        logic                       from_complete;
    } t_name_char;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [7:0]                 i_data_byte = '0;
    logic [bnx_pkg::LEN_W-1:0]  i_ad_length = '0;
    logic                       i_last_byte = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [bnx_pkg::CHAR_W-1:0] o_name_char;
    logic                       o_char_valid;
    logic                       o_name_last;
    logic                       o_from_complete;

    t_ad_request ad_requests_q[$];
    t_name_char  name_chars_due[$];
    logic [7:0]  report_bytes[$];
    t_pace       cur_pace = PACE_STEADY;
    int          mismatches = 0;

    // Predictor state, mirroring the parser of the block.
    t_parse_phase pr_phase;
    t_record_kind pr_kind;
    int           pr_offset;
    int           pr_left;
    logic [7:0]   pr_chars[bnx_pkg::NAME_DEPTH];
    int           pr_count;
    bit           pr_short_seen;
    bit           pr_complete_seen;

    ble_adv_name_extractor_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_ad_length    (i_ad_length),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_name_char    (o_name_char),
        .o_char_valid   (o_char_valid),
        .o_name_last    (o_name_last),
        .o_from_complete(o_from_complete)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_parser();
        pr_phase         = PH_LENGTH;
        pr_kind          = KIND_OTHER;
        pr_offset        = 0;
        pr_left          = 0;
        pr_count         = 0;
        pr_short_seen    = 1'b0;
        pr_complete_seen = 1'b0;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        report_bytes = {report_bytes, b};
    endfunction

    task automatic parse_ad_request(input logic [7:0] data,
                                    input logic [bnx_pkg::LEN_W-1:0] len_in,
                                    input logic last);
        int         len;
        int         b;
        t_name_char r;
        len = len_in;
        b   = data;
        if (len > bnx_pkg::MAX_AD_BYTES) len = bnx_pkg::MAX_AD_BYTES;
        if (len == 0) begin
            // An empty payload only answers its end marker.
            if (last) begin
                r = '{ch: '0, char_valid: 1'b0, name_last: 1'b1, from_complete: 1'b0};
                name_chars_due = {name_chars_due, r};
                clear_parser();
            end
            return;
        end
        if (pr_phase != PH_DONE && pr_offset >= len) pr_phase = PH_DONE;
        case (pr_phase)
            PH_LENGTH: begin
                if (b == 0 || pr_offset + b + 1 > len) begin
                    pr_phase = PH_DONE;
                end else begin
                    pr_left  = b;
                    pr_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                pr_left = pr_left - 1;
                pr_kind = KIND_OTHER;
                if (data == bnx_pkg::TYPE_COMPLETE && pr_left >= 1) begin
                    pr_kind          = KIND_COMPLETE;
                    pr_complete_seen = 1'b1;
                    pr_count         = 0;
                end else if (data == bnx_pkg::TYPE_SHORT && pr_left >= 1 &&
                             !pr_short_seen) begin
                    pr_kind       = KIND_SHORT;
                    pr_short_seen = 1'b1;
                    pr_count      = 0;
                end
                pr_phase = (pr_left == 0) ? PH_LENGTH : PH_VALUE;
            end
            PH_VALUE: begin
                if (pr_kind != KIND_OTHER && data >= bnx_pkg::CHAR_LOW &&
                    data <= bnx_pkg::CHAR_HIGH && pr_count < bnx_pkg::NAME_DEPTH) begin
                    pr_chars[pr_count] = data;
                    pr_count = pr_count + 1;
                end
                pr_left = pr_left - 1;
                if (pr_left == 0) pr_phase = (pr_kind == KIND_COMPLETE) ? PH_DONE : PH_LENGTH;
            end
            default: ;
        endcase
        if (pr_offset < 65535) pr_offset = pr_offset + 1;
        if (last) begin
            if (pr_count == 0) begin
                r = '{ch: '0, char_valid: 1'b0, name_last: 1'b1,
                      from_complete: pr_complete_seen};
                name_chars_due = {name_chars_due, r};
            end else begin
                for (int i = 0; i < pr_count; i++) begin
                    r = '{ch: pr_chars[i][bnx_pkg::CHAR_W-1:0], char_valid: 1'b1,
                          name_last: (i == pr_count - 1), from_complete: pr_complete_seen};
                    name_chars_due = {name_chars_due, r};
                end
            end
            clear_parser();
        end
    endtask

    // Sender: presents the next request once the previous one has gone.
    always @(posedge i_clk) begin : driver
        t_ad_request nxt;
        logic        take;
        logic        present;
        int          gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = i_in_valid && o_in_ready;
            if (take) parse_ad_request(i_data_byte, i_ad_length, i_last_byte);
            if (!i_in_valid || take) begin
                present = 1'b0;
                if (ad_requests_q.size() > 0) begin
                    nxt = ad_requests_q[0];
                    gap = (nxt.pace == PACE_SEND_GAPS) ? 82 :
                          (nxt.pace == PACE_BOTH_GAPS) ? 15 : 0;
                    if (nxt.drain && name_chars_due.size() > 0) begin
                        present = 1'b0;
                    end else if ($urandom_range(99) < gap) begin
                        present = 1'b0;
                    end else begin
                        present = 1'b1;
                        void'(ad_requests_q.pop_front());
                        cur_pace    <= nxt.pace;
                        i_data_byte <= nxt.data;
                        i_ad_length <= nxt.len;
                        i_last_byte <= nxt.last;
                    end
                end
                i_in_valid <= present;
            end
        end
    end

    // Receiver: checks each accepted result and stalls according to the pace.
    always @(posedge i_clk) begin : monitor
        t_name_char due;
        int         stall;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (name_chars_due.size() == 0) begin
                $error("unexpected result: char %0h valid %0b last %0b complete %0b",
                       o_name_char, o_char_valid, o_name_last, o_from_complete);
                mismatches++;
            end else begin
                due = name_chars_due.pop_front();
                if (o_name_char !== due.ch) begin
                    $error("name_char: expected %0h, got %0h", due.ch, o_name_char);
                    mismatches++;
                end
                if (o_char_valid !== due.char_valid) begin
                    $error("char_valid: expected %0b, got %0b", due.char_valid, o_char_valid);
                    mismatches++;
                end
                if (o_name_last !== due.name_last) begin
                    $error("name_last: expected %0b, got %0b", due.name_last, o_name_last);
                    mismatches++;
                end
                if (o_from_complete !== due.from_complete) begin
                    $error("from_complete: expected %0b, got %0b",
                           due.from_complete, o_from_complete);
                    mismatches++;
                end
            end
        end
        stall = (cur_pace == PACE_RECV_STALLS) ? 82 : (cur_pace == PACE_BOTH_GAPS) ? 15 : 0;
        i_out_ready <= ($urandom_range(99) >= stall);
    end

    task automatic push_request(input logic [7:0] data, input int len, input logic last,
                                input t_pace pace, input bit drain);
        t_ad_request rq;
        rq = '{data: data, len: len[bnx_pkg::LEN_W-1:0], last: last, pace: pace,
               drain: drain};
        ad_requests_q = {ad_requests_q, rq};
    endtask

    // Turns the bytes gathered in report_bytes into requests, the final one marked last.
    task automatic queue_report(input int len, input t_pace pace, input bit drain);
        for (int i = 0; i < report_bytes.size(); i++)
            push_request(report_bytes[i], len, i == report_bytes.size() - 1, pace,
                         drain && i == 0);
    endtask

    // A mostly well-formed payload of records, sometimes cut short or overlong.
    task automatic build_report(input t_pace pace, input bit drain);
        int         len;
        int         rem;
        int         l;
        int         pick;
        int         tail;
        bit         stop;
        logic [7:0] ty;
        report_bytes = {};
        stop = 1'b0;
        if ($urandom_range(9) == 0) begin
            // Longest possible name filling the whole payload.
            len = bnx_pkg::MAX_AD_BYTES;
            add_byte(8'(bnx_pkg::MAX_AD_BYTES - 1));
            add_byte($urandom_range(1) ? bnx_pkg::TYPE_COMPLETE : bnx_pkg::TYPE_SHORT);
            while (report_bytes.size() < len) add_byte(8'($urandom_range(32, 126)));
        end else begin
            len = $urandom_range(2) == 0 ? $urandom_range(1, 8) : $urandom_range(3, 31);
            while (report_bytes.size() < len) begin
                rem  = len - report_bytes.size();
                pick = $urandom_range(19);
                if (stop || rem < 2) begin
                    add_byte(8'($urandom));
                end else if (pick == 0) begin
                    add_byte(8'h00);
                    stop = 1'b1;
                end else if (pick == 1) begin
                    add_byte(8'(rem + $urandom_range(0, 4)));
                    stop = 1'b1;
                end else begin
                    l    = $urandom_range(1, rem - 1);
                    pick = $urandom_range(9);
                    ty   = (pick < 4) ? bnx_pkg::TYPE_COMPLETE :
                           (pick < 7) ? bnx_pkg::TYPE_SHORT : 8'($urandom);
                    add_byte(8'(l));
                    add_byte(ty);
                    for (int i = 1; i < l; i++)
                        add_byte($urandom_range(5) == 0 ? 8'($urandom) :
                                 8'($urandom_range(32, 126)));
                end
            end
        end
        tail = $urandom_range(9);
        if (tail == 0 && report_bytes.size() > 1) begin
            repeat ($urandom_range(1, report_bytes.size() - 1))
                void'(report_bytes.pop_back());
        end else if (tail == 1) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        end
        queue_report(len, pace, drain);
    endtask

    // Random bytes under a random length, which may even change within the payload.
    task automatic build_noise(input t_pace pace, input bit drain);
        int n;
        int len;
        n   = $urandom_range(1, 8);
        len = ($urandom_range(3) == 0) ? 0 : $urandom_range(31);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0) len = $urandom_range(31);
            push_request(8'($urandom), len, i == n - 1, pace, drain && i == 0);
        end
    endtask

    initial begin
        int    start;
        bit    first;
        t_pace pace;
        clear_parser();

        // Empty payload marker, and an empty-payload byte without the marker.
        push_request(8'hFF, 0, 1'b1, PACE_STEADY, 1'b0);
        push_request(8'hFF, 0, 1'b0, PACE_STEADY, 1'b0);
        push_request(8'h00, 0, 1'b1, PACE_STEADY, 1'b0);
        // Complete name with printable characters.
        report_bytes = {8'h03, bnx_pkg::TYPE_COMPLETE, 8'h48, 8'h69};
        queue_report(4, PACE_STEADY, 1'b0);
        // Complete name with nothing printable in it.
        report_bytes = {8'h03, bnx_pkg::TYPE_COMPLETE, 8'h01, 8'hFF};
        queue_report(4, PACE_STEADY, 1'b0);
        // Shortened name overridden by a later complete one, at both ends of the printable range.
        report_bytes = {8'h02, bnx_pkg::TYPE_SHORT, 8'h41, 8'h03, bnx_pkg::TYPE_COMPLETE,
                        8'h20, 8'h7E};
        queue_report(7, PACE_STEADY, 1'b0);
        // Final byte arriving before the declared end.
        report_bytes = {8'h05, bnx_pkg::TYPE_SHORT, 8'h61, 8'h62};
        queue_report(10, PACE_STEADY, 1'b0);
        // Bytes beyond the declared length.
        report_bytes = {8'h01, bnx_pkg::TYPE_SHORT, 8'h7F};
        queue_report(2, PACE_STEADY, 1'b0);

        for (int p = 0; p < 4; p++) begin
            pace  = t_pace'(p);
            start = ad_requests_q.size();
            first = 1'b1;
            while (ad_requests_q.size() - start < 125) begin
                if ($urandom_range(7) == 0) build_noise(pace, first);
                else build_report(pace, first);
                first = 1'b0;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (ad_requests_q.size() != 0 || i_in_valid || name_chars_due.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && name_chars_due.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
